// ===== hdl/spm_pkg.sv =====
package spm_pkg;

  // Number of samples held in the window
  localparam int WINDOW = 16;
  localparam int SAMPLE_W = 16;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam slot_t LAST_SLOT = slot_t'(WINDOW - 1);
  localparam fill_t FULL_COUNT = fill_t'(WINDOW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;    // store the incoming word and advance the ring
    logic clr;   // restart the scan
    logic rd;    // read the next stored sample
    logic load;  // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // current read is the last held sample
    logic out_free;   // output register can take a new word
  } status_t;

endpackage

// ===== hdl/spm_datapath.sv =====
module spm_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  spm_pkg::cmd_t        cmd,
  output spm_pkg::status_t     status,
  input  logic [15:0]          s_tdata,   // [15:0] sample
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata    // [15:0] midpoint
);

  spm_pkg::sample_t mem [spm_pkg::WINDOW];
  spm_pkg::slot_t   next_slot;
  spm_pkg::fill_t   fill_count;
  spm_pkg::slot_t   scan_idx;
  spm_pkg::sample_t rdata;
  logic             rd_vld;
  spm_pkg::sample_t hi;
  spm_pkg::sample_t lo;
  logic [spm_pkg::SAMPLE_W:0] sum;

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[next_slot] <= s_tdata;
    end
    if (cmd.rd) begin
      rdata <= mem[scan_idx];
    end
  end

  // Ring write pointer and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      next_slot  <= '0;
      fill_count <= '0;
    end else if (cmd.wr) begin
      next_slot <= (next_slot == spm_pkg::LAST_SLOT) ? '0 : next_slot + 1'b1;
      if (fill_count != spm_pkg::FULL_COUNT) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Scan pointer and read-data valid
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
      if (cmd.clr) begin
        scan_idx <= '0;
      end else if (cmd.rd) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  // Running max and min over the read samples
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      hi <= '0;
      lo <= '1;
    end else if (rd_vld) begin
      if (rdata > hi) hi <= rdata;
      if (rdata < lo) lo <= rdata;
    end
  end

  assign sum = {1'b0, hi} + {1'b0, lo};

  // Output register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= sum[spm_pkg::SAMPLE_W:1];
    end
  end

  assign status.scan_last = (spm_pkg::fill_t'(scan_idx) == fill_count - 1'b1);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

// ===== hdl/spm_ctrl.sv =====
module spm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  spm_pkg::status_t  status,
  output spm_pkg::cmd_t     cmd
);

  spm_pkg::state_t state;
  spm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      spm_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = spm_pkg::ST_SCAN;
      end
      spm_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = spm_pkg::ST_DRAIN;
      end
      spm_pkg::ST_DRAIN: begin
        state_next = spm_pkg::ST_FINISH;
      end
      spm_pkg::ST_FINISH: begin
        if (status.out_free) state_next = spm_pkg::ST_IDLE;
      end
      default: begin
        state_next = spm_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      spm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.wr   = s_tvalid;
        cmd.clr  = s_tvalid;
      end
      spm_pkg::ST_SCAN: begin
        cmd.rd = 1'b1;
      end
      spm_pkg::ST_FINISH: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/sliding_peak_midpoint_unit.sv =====
// Sliding-window peak midpoint.
// Input stream s_*: one 16-bit unsigned sample per word. Output stream m_*:
// one 16-bit word per sample, floor((max + min) / 2) over the most recent
// WINDOW samples (or all samples since reset while fewer are held).
// Each accepted word is written into a ring store, then the held samples are
// read back one per cycle through the single registered read port and folded
// into a running max and min. From accept to result an item goes through the
// write, the reads of the N held samples (N up to WINDOW), a drain step for
// the last read to land, and the load of the output register, which waits
// while the output register is busy. The next sample is taken in the cycle
// after the result is loaded, so the block takes no new sample while one
// is still being scanned.
// Reset (rst, synchronous) empties the window and drops any pending result.
// If the receiver stalls, the result waits in the output register; the
// block still accepts and scans the next sample and holds its result until
// the output register is free.
module sliding_peak_midpoint_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] midpoint
);

  spm_pkg::cmd_t    cmd;
  spm_pkg::status_t status;

  spm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spm_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/spm_checker.sv =====
module spm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output word changed while stalled");

  // Reset drops any pending result
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // One sample at a time: input closes after an accept
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second sample taken while scanning");

  // A result never appears right at the accept of a sample
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result without a scan");

endmodule

bind sliding_peak_midpoint_unit spm_checker u_spm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
